// ===== rtl/core/fbsc_pkg.sv =====
// Shared types, widths and register indexes for the frustum box and sphere culling block.
package fbsc_pkg;

   // Field widths fixed by the data formats.
   localparam int COORD_BITS        = 20;
   localparam int NORMAL_FRAC_BITS  = 12;
   localparam int NORMAL_FIELD_BITS = 14;
   localparam int DIST_FIELD_BITS   = 22;
   localparam int RADIUS_BITS       = 19;
   localparam int NUM_PLANES        = 4;
   localparam int PLANE_BITS        = 3 * NORMAL_FIELD_BITS + DIST_FIELD_BITS;
   localparam int CSR_DATA_BITS     = PLANE_BITS;
   localparam int CSR_INDEX_BITS    = 3;

   // Derived arithmetic widths.
   localparam int PROD_BITS  = NORMAL_FIELD_BITS + COORD_BITS;
   localparam int DOT_BITS   = PROD_BITS + 2;
   localparam int THR_BITS   = ((DIST_FIELD_BITS > RADIUS_BITS + 1) ?
                                DIST_FIELD_BITS : RADIUS_BITS + 1) + 1;
   localparam int THR_SCALED = THR_BITS + NORMAL_FRAC_BITS;
   localparam int CMP_BITS   = ((DOT_BITS > THR_SCALED) ? DOT_BITS : THR_SCALED) + 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_TOP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_CULLING = 3'd4;

   // Query kinds.
   localparam logic FUNC_BOX    = 1'b0;
   localparam logic FUNC_SPHERE = 1'b1;

   typedef logic signed [COORD_BITS-1:0]        coord_type;
   typedef logic signed [NORMAL_FIELD_BITS-1:0] normal_type;
   typedef logic signed [DIST_FIELD_BITS-1:0]   dist_type;
   typedef logic        [RADIUS_BITS-1:0]       radius_type;
   typedef logic        [NUM_PLANES-1:0]        plane_mask_type;

   // One plane as packed in its register, most significant field first.
   typedef struct packed {
      dist_type   distance;
      normal_type nz;
      normal_type ny;
      normal_type nx;
   } plane_type;

   // Shape payload of one query.
   typedef struct packed {
      logic       func;
      coord_type  lo_x;
      coord_type  lo_y;
      coord_type  lo_z;
      coord_type  hi_x;
      coord_type  hi_y;
      coord_type  hi_z;
      radius_type radius;
   } query_type;

   // Control that travels down the pipeline beside the payload.
   typedef struct packed {
      logic           valid;
      plane_mask_type enables;
      logic           skip;
   } ctrl_type;

endpackage

// ===== rtl/core/fbsc_plane_unit.sv =====
// Three-stage test of one query against one frustum plane: products, dot sum, compare.
module fbsc_plane_unit (
   input  logic               clock,
   input  fbsc_pkg::query_type query_in,
   input  fbsc_pkg::plane_type plane_in,
   output logic               hit_out
);

   logic signed [fbsc_pkg::PROD_BITS-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [fbsc_pkg::PROD_BITS-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [fbsc_pkg::THR_BITS-1:0]   thr_a_in, thr_a_ff, thr_b_ff;
   logic                                   func_a_ff, func_b_ff;
   logic signed [fbsc_pkg::DOT_BITS-1:0]   dot_in, dot_ff;
   logic signed [fbsc_pkg::CMP_BITS-1:0]   dot_ext, thr_ext;
   logic                                   hit_in, hit_ff;
   fbsc_pkg::coord_type                    cx, cy, cz;

   // Stage A: pick the corner farthest along the normal (center for a sphere) and multiply.
   always_comb begin
      if (query_in.func == fbsc_pkg::FUNC_SPHERE) begin
         cx = query_in.lo_x;
         cy = query_in.lo_y;
         cz = query_in.lo_z;
      end else begin
         cx = plane_in.nx[fbsc_pkg::NORMAL_FIELD_BITS-1] ? query_in.lo_x : query_in.hi_x;
         cy = plane_in.ny[fbsc_pkg::NORMAL_FIELD_BITS-1] ? query_in.lo_y : query_in.hi_y;
         cz = plane_in.nz[fbsc_pkg::NORMAL_FIELD_BITS-1] ? query_in.lo_z : query_in.hi_z;
      end
      prod_x_in = fbsc_pkg::PROD_BITS'(plane_in.nx) * fbsc_pkg::PROD_BITS'(cx);
      prod_y_in = fbsc_pkg::PROD_BITS'(plane_in.ny) * fbsc_pkg::PROD_BITS'(cy);
      prod_z_in = fbsc_pkg::PROD_BITS'(plane_in.nz) * fbsc_pkg::PROD_BITS'(cz);
      // A sphere is outside when dot <= (distance - radius) at the product scale.
      if (query_in.func == fbsc_pkg::FUNC_SPHERE) begin
         thr_a_in = fbsc_pkg::THR_BITS'(plane_in.distance)
                  - fbsc_pkg::THR_BITS'(query_in.radius);
      end else begin
         thr_a_in = fbsc_pkg::THR_BITS'(plane_in.distance);
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      thr_a_ff  <= thr_a_in;
      func_a_ff <= query_in.func;
   end

   // Stage B: sum the three products.
   assign dot_in = fbsc_pkg::DOT_BITS'(prod_x_ff) + fbsc_pkg::DOT_BITS'(prod_y_ff)
                 + fbsc_pkg::DOT_BITS'(prod_z_ff);

   always_ff @(posedge clock) begin
      dot_ff    <= dot_in;
      thr_b_ff  <= thr_a_ff;
      func_b_ff <= func_a_ff;
   end

   // Stage C: compare against the threshold scaled to the product's fraction bits.
   always_comb begin
      dot_ext = fbsc_pkg::CMP_BITS'(dot_ff);
      thr_ext = fbsc_pkg::CMP_BITS'(thr_b_ff) <<< fbsc_pkg::NORMAL_FRAC_BITS;
      if (func_b_ff == fbsc_pkg::FUNC_SPHERE) begin
         hit_in = (dot_ext <= thr_ext);
      end else begin
         hit_in = (dot_ext < thr_ext);
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   assign hit_out = hit_ff;

endmodule

// ===== rtl/core/frustum_box_sphere_cull.sv =====
// Top level of the frustum culling block for axis-aligned boxes and spheres.
// One query is accepted on every clock where start is high; busy is never raised, so
// queries may follow each other back to back with no gaps. Each query yields exactly
// one beat on rsp_strobe/rsp_culled after passing through the pipeline below, in
// order; the receiver cannot stall, so results must be taken when the strobe is seen.
// The pipeline holds an input register, then a multiply stage, a dot
// sum stage and a compare stage run in parallel for the four planes, then the output
// register that merges the plane hits. Plane registers and the skip bit are to be written
// through the csr port only while no query is in flight; the block does not enforce this.
module frustum_box_sphere_cull (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_func,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_low_x,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_low_y,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_low_z,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_high_x,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_high_y,
   input  logic signed [fbsc_pkg::COORD_BITS-1:0] req_high_z,
   input  logic        [fbsc_pkg::RADIUS_BITS-1:0] req_sphere_radius,
   input  logic        [fbsc_pkg::NUM_PLANES-1:0]  req_plane_enables,
   output logic                                  rsp_strobe,
   output logic                                  rsp_culled,
   input  logic                                  csr_we,
   input  logic [fbsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fbsc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [fbsc_pkg::PLANE_BITS-1:0] plane_ff [fbsc_pkg::NUM_PLANES];
   logic                            skip_ff;
   fbsc_pkg::query_type             query_in, query_ff;
   fbsc_pkg::ctrl_type              ctl_s0_in, ctl_s0_ff, ctl_a_ff, ctl_b_ff, ctl_c_ff;
   fbsc_pkg::plane_mask_type        hits;
   logic                            rsp_strobe_ff, rsp_culled_ff;
   logic                            rsp_culled_in;

   // The pipeline never stalls, so a query is taken on every start.
   assign busy = 1'b0;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fbsc_pkg::NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         skip_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            fbsc_pkg::CSR_PLANE_LEFT:   plane_ff[0] <= csr_wdata;
            fbsc_pkg::CSR_PLANE_RIGHT:  plane_ff[1] <= csr_wdata;
            fbsc_pkg::CSR_PLANE_BOTTOM: plane_ff[2] <= csr_wdata;
            fbsc_pkg::CSR_PLANE_TOP:    plane_ff[3] <= csr_wdata;
            fbsc_pkg::CSR_SKIP_CULLING: skip_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input register stage.
   always_comb begin
      query_in.func     = req_func;
      query_in.lo_x     = req_low_x;
      query_in.lo_y     = req_low_y;
      query_in.lo_z     = req_low_z;
      query_in.hi_x     = req_high_x;
      query_in.hi_y     = req_high_y;
      query_in.hi_z     = req_high_z;
      query_in.radius   = req_sphere_radius;
      ctl_s0_in.valid   = start && !busy;
      ctl_s0_in.enables = req_plane_enables;
      ctl_s0_in.skip    = skip_ff;
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
   end

   // Control pipeline, aligned with the three stages inside each plane unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s0_ff <= '0;
         ctl_a_ff  <= '0;
         ctl_b_ff  <= '0;
         ctl_c_ff  <= '0;
      end else begin
         ctl_s0_ff <= ctl_s0_in;
         ctl_a_ff  <= ctl_s0_ff;
         ctl_b_ff  <= ctl_a_ff;
         ctl_c_ff  <= ctl_b_ff;
      end
   end

   // One test unit per frustum plane.
   for (genvar p = 0; p < fbsc_pkg::NUM_PLANES; p++) begin : g_plane
      fbsc_plane_unit u_plane (
         .clock    (clock),
         .query_in (query_ff),
         .plane_in (fbsc_pkg::plane_type'(plane_ff[p])),
         .hit_out  (hits[p])
      );
   end

   // Output stage: culled when culling is not skipped and any enabled plane rejects the shape.
   assign rsp_culled_in = ctl_c_ff.valid && !ctl_c_ff.skip && |(hits & ctl_c_ff.enables);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rsp_culled_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_c_ff.valid;
         rsp_culled_ff <= rsp_culled_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_culled = rsp_culled_ff;

endmodule

// ===== rtl/core/fbsc_checker.sv =====
// Port-level checks for the frustum culling block, bound to its top level.
module fbsc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [fbsc_pkg::NUM_PLANES-1:0]      req_plane_enables,
   input logic                                 rsp_strobe,
   input logic                                 rsp_culled
);

   // Every accepted query gives its result beat.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("accepted query produced no result beat");

   // No result beat appears without a matching query accepted before it.
   a_rsp_has_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("result beat without a matching query");

   // A query with no plane enabled is never culled.
   a_no_planes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_plane_enables == '0)) |-> ##5 !rsp_culled)
      else $error("query with no enabled plane reported culled");

   // The culled flag only shows with a result beat.
   a_culled_qualified: assert property (@(posedge clock) disable iff (reset)
      rsp_culled |-> rsp_strobe)
      else $error("culled raised outside a result beat");

endmodule

bind frustum_box_sphere_cull fbsc_checker u_fbsc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_plane_enables (req_plane_enables),
   .rsp_strobe        (rsp_strobe),
   .rsp_culled        (rsp_culled)
);
